@@ rtl/sorted_table_insert_delete_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_DELETE_TOP_MACROS_SVH
`define SORTED_TABLE_INSERT_DELETE_TOP_MACROS_SVH

// same-cycle implication
`define STID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/stid_pkg.sv @@
// ----------------------------------------------------------------------------
// stid_pkg
// Codes, widths and the result type shared by the sorted table modules.
// ----------------------------------------------------------------------------
package stid_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 6;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_DUMP   = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DELETED   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_ENTRY     = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	typedef struct packed {
		logic [2:0]               status;
		logic signed [DATA_W-1:0] value;
		logic [COUNT_W-1:0]       count;
		logic                     last;
	} res_t;

endpackage

@@ rtl/sorted_table_insert_delete_top.sv @@
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_top
// Sorted table of signed 32-bit values with insert, delete and dump requests.
// ----------------------------------------------------------------------------
// Holds up to CAPACITY values in ascending order in a single-port-read table
// memory. An insert walks down from the tail, shifting up each entry greater
// than the value, and a delete walks the whole table. The single result then
// passes through the finishing state into the output register. An insert
// into a full table or a dump of an empty one goes straight to that state.
// A dump reads each entry in turn and pushes it as its own result. The
// sequencer visits the entries through the one memory read port and the one
// comparator. A new request is taken from the cycle after the previous one's
// last result has entered the output register, while that result may still
// wait there; a stalled receiver holds the sequencer. Requests of mode three
// are taken and dropped with no result. No clearing pass runs after reset.
module sorted_table_insert_delete_top
	import stid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                status,
	output logic signed [DATA_W-1:0]  entry_value,
	output logic [COUNT_W-1:0]        entry_count,
	output logic                      last
);

	`include "sorted_table_insert_delete_top_macros.svh"

	res_t res;
	logic res_push;
	logic slot_free;
	logic out_valid_q;
	res_t out_q;

	assign slot_free = !out_valid_q || out_ready;

	stid_engine #(
		.CAPACITY (CAPACITY)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_mode   (mode),
		.in_value  (value),
		.slot_free (slot_free),
		.res_push  (res_push),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign entry_value = out_q.value;
	assign entry_count = out_q.count;
	assign last        = out_q.last;

	`STID_ASSERT_NOW(a_push_slot, res_push, slot_free, "result pushed into a full output register")
	`STID_ASSERT_NOW(a_push_busy, res_push, !in_ready, "result pushed while accepting requests")
	`STID_ASSERT_NEXT(a_zero_val, res_push && res.status != ST_ENTRY, entry_value == '0, "value set")

endmodule

@@ rtl/stid_engine.sv @@
// ----------------------------------------------------------------------------
// stid_engine
// Table memory, one shared comparator and the sequencer that walks the table
// one entry a cycle for insert and delete, and entry by entry for dump.
// ----------------------------------------------------------------------------
module stid_engine
	import stid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               in_mode,
	input  logic signed [DATA_W-1:0] in_value,
	input  logic                     slot_free,
	output logic                     res_push,
	output res_t                     res
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_INS  = 6'b000010,
		S_DEL  = 6'b000100,
		S_DRD  = 6'b001000,
		S_DLD  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            ptr_q;
	logic                     pend_s1;
	logic                     found_q;
	logic [AW-1:0]            paddr_s1;
	logic signed [DATA_W-1:0] val_q;
	logic [2:0]               fin_status_q;

	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic signed [DATA_W-1:0] rdata_q;

	logic                     re;
	logic [AW-1:0]            raddr;
	logic                     we;
	logic [AW-1:0]            waddr;
	logic signed [DATA_W-1:0] wdata;
	logic                     cmp_lt;
	logic                     cmp_eq;
	logic                     ins_done;
	logic                     del_done;

	assign cmp_lt   = val_q < rdata_q;
	assign cmp_eq   = val_q == rdata_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		re         = 1'b0;
		raddr      = '0;
		we         = 1'b0;
		waddr      = '0;
		wdata      = rdata_q;
		ins_done   = 1'b0;
		del_done   = 1'b0;
		res_push   = 1'b0;
		res.status = fin_status_q;
		res.value  = '0;
		res.count  = COUNT_W'(cnt_q);
		res.last   = 1'b1;
		case (state_q)
			S_INS: begin
				// walk down from the tail, shifting up until the slot is found
				if (pend_s1) begin
					we    = 1'b1;
					waddr = paddr_s1 + AW'(1);
					wdata = cmp_lt ? rdata_q : val_q;
				end else if (ptr_q == '0) begin
					we    = 1'b1;
					waddr = '0;
					wdata = val_q;
				end
				ins_done = (pend_s1 && !cmp_lt) || (!pend_s1 && ptr_q == '0);
				re       = (ptr_q != '0) && !ins_done;
				raddr    = AW'(ptr_q - CW'(1));
			end
			S_DEL: begin
				// walk up; after the match every entry moves down one place
				if (pend_s1 && found_q) begin
					we    = 1'b1;
					waddr = paddr_s1 - AW'(1);
					wdata = rdata_q;
				end
				re       = (ptr_q != cnt_q);
				raddr    = AW'(ptr_q);
				del_done = !pend_s1 && (ptr_q == cnt_q);
			end
			S_DRD: begin
				re    = 1'b1;
				raddr = AW'(ptr_q);
			end
			S_DLD: begin
				res_push   = slot_free;
				res.status = ST_ENTRY;
				res.value  = rdata_q;
				res.last   = (ptr_q == cnt_q);
			end
			S_FIN: begin
				res_push = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ptr_q   <= '0;
			pend_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						found_q <= 1'b0;
						pend_s1 <= 1'b0;
						case (in_mode)
							MODE_INSERT: begin
								if (cnt_q >= CW'(CAPACITY)) begin
									state_q <= S_FIN;
								end else begin
									ptr_q   <= cnt_q;
									state_q <= S_INS;
								end
							end
							MODE_DELETE: begin
								ptr_q   <= '0;
								state_q <= S_DEL;
							end
							MODE_DUMP: begin
								ptr_q   <= '0;
								state_q <= (cnt_q == '0) ? S_FIN : S_DRD;
							end
							default: ;
						endcase
					end
				end
				S_INS: begin
					pend_s1 <= re;
					if (re) begin
						ptr_q <= ptr_q - CW'(1);
					end
					if (ins_done) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_DEL: begin
					pend_s1 <= re;
					if (re) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (pend_s1 && !found_q && cmp_eq) begin
						found_q <= 1'b1;
					end
					if (del_done) begin
						if (found_q) begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= S_FIN;
					end
				end
				S_DRD: begin
					ptr_q   <= ptr_q + CW'(1);
					state_q <= S_DLD;
				end
				S_DLD: begin
					if (slot_free) begin
						state_q <= (ptr_q == cnt_q) ? S_IDLE : S_DRD;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			val_q        <= in_value;
			fin_status_q <= (in_mode == MODE_INSERT) ? ST_FULL : ST_EMPTY;
		end else if (state_q == S_INS && ins_done) begin
			fin_status_q <= ST_INSERTED;
		end else if (state_q == S_DEL && del_done) begin
			fin_status_q <= found_q ? ST_DELETED : ST_NOT_FOUND;
		end
		if (re) begin
			paddr_s1 <= raddr;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

@@ tb/sv/tb_sorted_table_insert_delete_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_delete_top
// Self-checking bench for the sorted table. A short table of directed requests
// covers the edge cases. Random traffic follows in four idle/stall phases,
// each a mix of requests, a fill past capacity and a drain to empty. Every
// result is checked against a typed row or a shadow table kept in the bench.
// ----------------------------------------------------------------------------
module tb_sorted_table_insert_delete_top;
	import stid_pkg::*;

	localparam int                       CAPACITY     = CAPACITY_DEF;
	localparam logic [1:0]               MODE_UNUSED  = 2'd3;
	localparam logic signed [DATA_W-1:0] VAL_MIN      = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX      = 32'sh7FFF_FFFF;
	localparam int                       LIMIT_CYCLES = 1_000_000;
	localparam int                       DRAIN_CYCLES = 2 * CAPACITY + 16;
	localparam int                       REPORT_MAX   = 10;
	localparam int                       MIXED_ITEMS  = 28;
	localparam int                       MAX_GAP      = 100;
	localparam int                       SEND_IDLE_PCT  [4] = '{0, 88, 0, 25};
	localparam int                       RECV_STALL_PCT [4] = '{0, 0, 88, 25};

	typedef struct packed {
		logic [1:0]               req_mode;
		logic signed [DATA_W-1:0] req_value;
		logic                     typed;
		res_t                     given;
	} directed_row_t;

	localparam int NUM_DIRECTED = 21;
	localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
		'{MODE_DUMP,   VAL_MAX,     1'b1, '{ST_EMPTY,     32'sd0, 6'd0, 1'b1}},
		'{MODE_DELETE, 32'sd5,      1'b1, '{ST_NOT_FOUND, 32'sd0, 6'd0, 1'b1}},
		'{MODE_INSERT, VAL_MAX,     1'b1, '{ST_INSERTED,  32'sd0, 6'd1, 1'b1}},
		'{MODE_INSERT, VAL_MIN,     1'b1, '{ST_INSERTED,  32'sd0, 6'd2, 1'b1}},
		'{MODE_INSERT, 32'sd0,      1'b1, '{ST_INSERTED,  32'sd0, 6'd3, 1'b1}},
		'{MODE_INSERT, 32'sd0,      1'b1, '{ST_INSERTED,  32'sd0, 6'd4, 1'b1}},
		'{MODE_INSERT, -32'sd1,     1'b1, '{ST_INSERTED,  32'sd0, 6'd5, 1'b1}},
		'{MODE_UNUSED, -32'sd1,     1'b0, '0},
		'{MODE_DUMP,   32'sd0,      1'b0, '0},
		'{MODE_DELETE, 32'sd0,      1'b1, '{ST_DELETED,   32'sd0, 6'd4, 1'b1}},
		'{MODE_DELETE, 32'sd12345,  1'b1, '{ST_NOT_FOUND, 32'sd0, 6'd4, 1'b1}},
		'{MODE_DELETE, VAL_MIN,     1'b1, '{ST_DELETED,   32'sd0, 6'd3, 1'b1}},
		'{MODE_DELETE, VAL_MAX,     1'b1, '{ST_DELETED,   32'sd0, 6'd2, 1'b1}},
		'{MODE_DUMP,   VAL_MIN,     1'b0, '0},
		'{MODE_DELETE, 32'sd0,      1'b1, '{ST_DELETED,   32'sd0, 6'd1, 1'b1}},
		'{MODE_DELETE, -32'sd1,     1'b1, '{ST_DELETED,   32'sd0, 6'd0, 1'b1}},
		'{MODE_DUMP,   -32'sd1,     1'b1, '{ST_EMPTY,     32'sd0, 6'd0, 1'b1}},
		'{MODE_DELETE, VAL_MIN,     1'b1, '{ST_NOT_FOUND, 32'sd0, 6'd0, 1'b1}},
		'{MODE_INSERT, 32'sd7,      1'b1, '{ST_INSERTED,  32'sd0, 6'd1, 1'b1}},
		'{MODE_DUMP,   32'sd0,      1'b0, '0},
		'{MODE_DELETE, 32'sd7,      1'b1, '{ST_DELETED,   32'sd0, 6'd0, 1'b1}}
	};

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [1:0]               mode      = MODE_INSERT;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [2:0]               status;
	logic signed [DATA_W-1:0] entry_value;
	logic [COUNT_W-1:0]       entry_count;
	logic                     last;

	logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
	int                       shadow_fill = 0;
	res_t                     awaited_results [$];
	int                       error_count = 0;
	int                       cycle_count = 0;
	int                       send_idle_pct = 0;
	int                       recv_stall_pct = 0;

	sorted_table_insert_delete_top #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.entry_value(entry_value),
		.entry_count(entry_count),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= REPORT_MAX)
			$display("%0t: %s", $time, msg);
	endtask

	// shadow table update and expected results for one accepted request
	task automatic predict_table_results(input logic [1:0] req_mode,
			input logic signed [DATA_W-1:0] req_value);
		int   pos;
		res_t r;
		r      = '0;
		r.last = 1'b1;
		case (req_mode)
			MODE_INSERT: begin
				if (shadow_fill >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_fill && req_value >= shadow_entries[pos])
						pos++;
					for (int i = shadow_fill; i > pos; i--)
						shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[pos] = req_value;
					shadow_fill++;
					r.status = ST_INSERTED;
				end
			end
			MODE_DELETE: begin
				pos = 0;
				while (pos < shadow_fill && shadow_entries[pos] != req_value)
					pos++;
				if (pos == shadow_fill) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < shadow_fill; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_fill--;
					r.status = ST_DELETED;
				end
			end
			MODE_DUMP: begin
				r.status = ST_EMPTY;
				for (int i = 0; i < shadow_fill; i++) begin
					r.status = ST_ENTRY;
					r.value  = shadow_entries[i];
					r.count  = COUNT_W'(shadow_fill);
					r.last   = (i == shadow_fill - 1);
					if (!r.last)
						awaited_results.push_back(r);
				end
			end
			default: begin
				return;
			end
		endcase
		r.count = COUNT_W'(shadow_fill);
		awaited_results.push_back(r);
	endtask

	// called at the acceptance edge of the previous request
	task automatic send_request(input logic [1:0] req_mode,
			input logic signed [DATA_W-1:0] req_value,
			input logic use_given = 1'b0, input res_t given = '0);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= req_mode;
		value    <= req_value;
		do @(posedge clk); while (!in_ready);
		predict_table_results(req_mode, req_value);
		if (use_given) begin
			void'(awaited_results.pop_back());
			awaited_results.push_back(given);
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2, 3, 4: return $signed($urandom_range(16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// mostly values held, so deletes reach into the table
	function automatic logic signed [DATA_W-1:0] pick_delete_value();
		if (shadow_fill > 0 && $urandom_range(3) != 0)
			return shadow_entries[$urandom_range(shadow_fill - 1)];
		return pick_value();
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				flag_error($sformatf("unexpected result: status %0d value %0d count %0d last %0b",
					status, entry_value, entry_count, last));
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status || entry_value !== want.value
						|| entry_count !== want.count || last !== want.last)
					flag_error($sformatf({"mismatch: exp status %0d value %0d count %0d last %0b,",
						" got status %0d value %0d count %0d last %0b"},
						want.status, want.value, want.count, want.last,
						status, entry_value, entry_count, last));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int sel;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_request(DIRECTED[i].req_mode, DIRECTED[i].req_value,
				DIRECTED[i].typed, DIRECTED[i].given);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = SEND_IDLE_PCT[p];
			recv_stall_pct = RECV_STALL_PCT[p];
			for (int k = 0; k < MIXED_ITEMS; k++) begin
				sel = $urandom_range(99);
				if (sel < 45)
					send_request(MODE_INSERT, pick_value());
				else if (sel < 82)
					send_request(MODE_DELETE, pick_delete_value());
				else if (sel < 96)
					send_request(MODE_DUMP, $urandom);
				else
					send_request(MODE_UNUSED, $urandom);
			end
			// fill past capacity
			while (shadow_fill < CAPACITY)
				send_request(MODE_INSERT, pick_value());
			repeat ($urandom_range(3, 1))
				send_request(MODE_INSERT, pick_value());
			send_request(MODE_DUMP, $urandom);
			// drain to empty
			while (shadow_fill > 0) begin
				if ($urandom_range(99) < 10)
					send_request(MODE_DUMP, $urandom);
				else
					send_request(MODE_DELETE, pick_delete_value());
			end
			send_request(MODE_DELETE, pick_value());
			send_request(MODE_DUMP, $urandom);
		end

		in_valid <= 1'b0;
		recv_stall_pct = 0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
